/* hw/rtl/assert_macros.svh */
// Assertion macros used by the countdown timer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked check that is switched off while reset is high.
`define CDT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds around reset.
`define CDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CDT_ASSERT(lbl, clk, rst, prop, msg)
`define CDT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* hw/rtl/cdt_pkg.sv */
// Types, codes and constants of the countdown timer.
package cdt_pkg;

   // Configuration port geometry.
   localparam int CSR_ADDR_WIDTH = 8;
   localparam int CSR_DATA_WIDTH = 8;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_BLINK_TICKS  = 8'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_REPORT_TICKS = 8'd1;

   // Configuration reset values.
   localparam logic [7:0] BLINK_TICKS_RESET  = 8'd5;
   localparam logic [7:0] REPORT_TICKS_RESET = 8'd100;

   // Event codes.
   localparam logic [2:0] MODE_TICK  = 3'd0;
   localparam logic [2:0] MODE_LOAD  = 3'd1;
   localparam logic [2:0] MODE_START = 3'd2;
   localparam logic [2:0] MODE_PAUSE = 3'd3;
   localparam logic [2:0] MODE_STOP  = 3'd4;

   // Largest legal digit values.
   localparam logic [5:0] MINUTES_TOP = 6'd59;
   localparam logic [5:0] SECONDS_TOP = 6'd59;
   localparam logic [3:0] TENTHS_TOP  = 4'd9;

   // Display state.
   typedef enum logic [1:0] {
      SHOW_INPUT = 2'd0,
      SHOW_RUN   = 2'd1,
      SHOW_PAUSE = 2'd2,
      SHOW_STOP  = 2'd3
   } show_type;

   // One request beat.
   typedef struct packed {
      logic [2:0] mode;
      logic [6:0] load_minutes;
      logic [6:0] load_seconds;
      logic [3:0] load_tenths;
   } req_beat_type;

   // One response beat.
   typedef struct packed {
      logic [5:0] minutes_left;
      logic [5:0] seconds_left;
      logic [3:0] tenths_left;
      show_type   shown_state;
      logic       led_lit;
      logic       report_pulse;
      logic       expired;
      logic       load_rejected;
   } rsp_beat_type;

   // Configuration write as seen by the core.
   typedef struct packed {
      logic                      write;
      logic [CSR_ADDR_WIDTH-1:0] addr;
      logic [CSR_DATA_WIDTH-1:0] wdata;
   } csr_write_type;

endpackage

/* hw/rtl/cdt_if.sv */
// Valid/ready channel interfaces of the countdown timer.

// Request channel: one event per beat.
interface cdt_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [6:0] load_minutes;
   logic [6:0] load_seconds;
   logic [3:0] load_tenths;

   modport source (output valid, output mode, output load_minutes, output load_seconds,
                   output load_tenths, input ready);
   modport sink   (input valid, input mode, input load_minutes, input load_seconds,
                   input load_tenths, output ready);
endinterface

// Response channel: the time and flags after each event.
interface cdt_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] minutes_left;
   logic [5:0] seconds_left;
   logic [3:0] tenths_left;
   logic [1:0] shown_state;
   logic       led_lit;
   logic       report_pulse;
   logic       expired;
   logic       load_rejected;

   modport source (output valid, output minutes_left, output seconds_left,
                   output tenths_left, output shown_state, output led_lit,
                   output report_pulse, output expired, output load_rejected, input ready);
   modport sink   (input valid, input minutes_left, input seconds_left,
                   input tenths_left, input shown_state, input led_lit,
                   input report_pulse, input expired, input load_rejected, output ready);
endinterface

// Configuration write channel.
interface cdt_csr_if import cdt_pkg::*; ;
   logic                      valid;
   logic                      ready;
   logic [CSR_ADDR_WIDTH-1:0] addr;
   logic [CSR_DATA_WIDTH-1:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

/* hw/rtl/cdt_in_stage.sv */
// Input register of the countdown timer: holds one accepted request beat.
module cdt_in_stage import cdt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  req_beat_type in_item,
   output logic         in_ready,
   input  logic         advance,
   output logic         held_valid,
   output req_beat_type held_item
);

   logic         valid_ff;
   logic         valid_in;
   req_beat_type item_ff;

   // The register frees up in the same cycle that its beat moves on.
   assign in_ready = !valid_ff || advance;

   always_comb begin
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

/* hw/rtl/cdt_core.sv */
// Timer state and per-event update logic of the countdown timer.
`include "assert_macros.svh"

module cdt_core import cdt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  req_beat_type  item,
   input  csr_write_type csr,
   output rsp_beat_type  res
);

   logic [7:0] blink_ticks_ff;
   logic [7:0] report_ticks_ff;

   logic [5:0] minutes_ff, minutes_in;
   logic [5:0] seconds_ff, seconds_in;
   logic [3:0] tenths_ff, tenths_in;
   logic       armed_ff, armed_in;
   logic       running_ff, running_in;
   show_type   show_ff, show_in;
   logic       led_ff, led_in;
   logic [7:0] blink_ff, blink_in;
   logic [7:0] report_ff, report_in;
   logic [3:0] loaded_tenths_ff, loaded_tenths_in;

   logic       pulse;
   logic       expire;
   logic       rejected;
   logic [8:0] blink_sum;
   logic [8:0] report_sum;
   logic       load_ok;

   // Configuration registers; the user must write them only while the block is idle (not enforced here).
   always_ff @(posedge clock) begin
      if (reset) begin
         blink_ticks_ff  <= BLINK_TICKS_RESET;
         report_ticks_ff <= REPORT_TICKS_RESET;
      end else if (csr.write) begin
         case (csr.addr)
            CSR_BLINK_TICKS:  blink_ticks_ff  <= csr.wdata;
            CSR_REPORT_TICKS: report_ticks_ff <= csr.wdata;
            default: begin
            end
         endcase
      end
   end

   // Counter sums are one bit wider so a count of 255 still wraps.
   assign blink_sum  = {1'b0, blink_ff} + 9'd1;
   assign report_sum = {1'b0, report_ff} + 9'd1;
   assign load_ok    = (item.load_minutes <= {1'b0, MINUTES_TOP})
                    && (item.load_seconds <= {1'b0, SECONDS_TOP})
                    && (item.load_tenths <= TENTHS_TOP);

   // Next state for the event held in the input register.
   always_comb begin
      minutes_in       = minutes_ff;
      seconds_in       = seconds_ff;
      tenths_in        = tenths_ff;
      armed_in         = armed_ff;
      running_in       = running_ff;
      show_in          = show_ff;
      led_in           = led_ff;
      blink_in         = blink_ff;
      report_in        = report_ff;
      loaded_tenths_in = loaded_tenths_ff;
      pulse            = 1'b0;
      expire           = 1'b0;
      rejected         = 1'b0;

      case (item.mode)
         MODE_TICK: begin
            if (running_ff) begin
               // Decrement with borrow; at zero the count expires.
               if (tenths_ff != 4'd0) begin
                  tenths_in = tenths_ff - 4'd1;
               end else if (seconds_ff != 6'd0) begin
                  seconds_in = seconds_ff - 6'd1;
                  tenths_in  = TENTHS_TOP;
               end else if (minutes_ff != 6'd0) begin
                  minutes_in = minutes_ff - 6'd1;
                  seconds_in = SECONDS_TOP;
                  tenths_in  = TENTHS_TOP;
               end else begin
                  expire = 1'b1;
               end

               // Blink counter toggles the LED when it reaches its limit.
               if (blink_sum >= {1'b0, blink_ticks_ff}) begin
                  blink_in = 8'd0;
                  led_in   = !led_ff;
               end else begin
                  blink_in = blink_sum[7:0];
               end

               // Report check looks at the tenths left after this tick.
               if (report_sum >= {1'b0, report_ticks_ff}) begin
                  report_in = 8'd0;
                  pulse     = (tenths_in == loaded_tenths_ff);
               end else begin
                  report_in = report_sum[7:0];
               end

               if (expire) begin
                  running_in = 1'b0;
                  armed_in   = 1'b0;
                  show_in    = SHOW_STOP;
                  led_in     = 1'b1;
               end
            end
         end
         MODE_LOAD: begin
            if (!armed_ff) begin
               if (load_ok) begin
                  minutes_in       = item.load_minutes[5:0];
                  seconds_in       = item.load_seconds[5:0];
                  tenths_in        = item.load_tenths;
                  loaded_tenths_in = item.load_tenths;
                  armed_in         = 1'b1;
                  led_in           = 1'b0;
               end else begin
                  rejected = 1'b1;
               end
            end
         end
         MODE_START: begin
            if (armed_ff) begin
               running_in = 1'b1;
               show_in    = SHOW_RUN;
            end
         end
         MODE_PAUSE: begin
            if (armed_ff) begin
               running_in = 1'b0;
               led_in     = 1'b1;
               show_in    = SHOW_PAUSE;
            end
         end
         MODE_STOP: begin
            if (armed_ff) begin
               minutes_in = 6'd0;
               seconds_in = 6'd0;
               tenths_in  = 4'd0;
               report_in  = 8'd0;
               running_in = 1'b0;
               armed_in   = 1'b0;
               led_in     = 1'b0;
               show_in    = SHOW_STOP;
            end
         end
         default: begin
         end
      endcase
   end

   // Response fields reflect the state after the event.
   always_comb begin
      res.minutes_left  = minutes_in;
      res.seconds_left  = seconds_in;
      res.tenths_left   = tenths_in;
      res.shown_state   = show_in;
      res.led_lit       = led_in;
      res.report_pulse  = pulse;
      res.expired       = expire;
      res.load_rejected = rejected;
   end

   // State commits only when the event moves into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         minutes_ff       <= 6'd0;
         seconds_ff       <= 6'd0;
         tenths_ff        <= 4'd0;
         armed_ff         <= 1'b0;
         running_ff       <= 1'b0;
         show_ff          <= SHOW_INPUT;
         led_ff           <= 1'b1;
         blink_ff         <= 8'd0;
         report_ff        <= 8'd0;
         loaded_tenths_ff <= 4'd0;
      end else if (advance) begin
         minutes_ff       <= minutes_in;
         seconds_ff       <= seconds_in;
         tenths_ff        <= tenths_in;
         armed_ff         <= armed_in;
         running_ff       <= running_in;
         show_ff          <= show_in;
         led_ff           <= led_in;
         blink_ff         <= blink_in;
         report_ff        <= report_in;
         loaded_tenths_ff <= loaded_tenths_in;
      end
   end

   `CDT_ASSERT(a_run_needs_arm, clock, reset, running_ff |-> armed_ff, "running while unarmed")
   `CDT_ASSERT(a_time_range, clock, reset, (tenths_ff <= TENTHS_TOP) && (seconds_ff <= SECONDS_TOP) && (minutes_ff <= MINUTES_TOP), "time digit out of range")
   `CDT_ASSERT(a_expire_disarms, clock, reset, (advance && res.expired) |=> (!armed_ff && !running_ff && led_ff), "expiry left the timer armed")
   `CDT_ASSERT(a_reject_only_load, clock, reset, res.load_rejected |-> ((item.mode == MODE_LOAD) && !armed_ff), "rejection outside an unarmed load")
   `CDT_ASSERT_ALWAYS(a_reset_state, clock, reset |=> (led_ff && !armed_ff && !running_ff), "reset did not restore the idle state")

endmodule

/* hw/rtl/cdt_out_stage.sv */
// Result register of the countdown timer: holds one response beat until taken.
module cdt_out_stage import cdt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_beat_type load_item,
   output logic         space,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_beat_type out_item
);

   logic         valid_ff;
   logic         valid_in;
   rsp_beat_type item_ff;

   // A new beat may enter while the current one is being taken.
   assign space = !valid_ff || out_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

/* hw/rtl/countdown_timer_min_sec_tenths.sv */
// Countdown timer, minutes, seconds and tenths: one response beat per request beat.
// Each request beat is one event (tick, load, start, pause or stop) and returns
// exactly one response beat carrying the remaining time and flags after that event.
// The block takes one beat every clock cycle while responses are taken: the event sits
// in an input register, the whole state update is one pass of logic, and the response
// is registered in the result register once it has room; while a response waits, one
// more request can be held, and only then does req_chan.ready drop. Configuration
// writes are always taken and should be issued only while no event is in flight.
module countdown_timer_min_sec_tenths import cdt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cdt_req_if.sink   req_chan,
   cdt_rsp_if.source rsp_chan,
   cdt_csr_if.sink   csr_chan
);

   req_beat_type  req_item;
   req_beat_type  held_item;
   rsp_beat_type  core_res;
   rsp_beat_type  rsp_item;
   csr_write_type csr;
   logic          held_valid;
   logic          out_space;
   logic          advance;

   // Gather the request fields into one beat.
   always_comb begin
      req_item.mode         = req_chan.mode;
      req_item.load_minutes = req_chan.load_minutes;
      req_item.load_seconds = req_chan.load_seconds;
      req_item.load_tenths  = req_chan.load_tenths;
   end

   // Configuration writes complete at once.
   assign csr_chan.ready = 1'b1;
   always_comb begin
      csr.write = csr_chan.valid;
      csr.addr  = csr_chan.addr;
      csr.wdata = csr_chan.wdata;
   end

   // A held event is processed when the result register has room.
   assign advance = held_valid && out_space;

   cdt_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_item    (req_item),
      .in_ready   (req_chan.ready),
      .advance    (advance),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   cdt_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (held_item),
      .csr     (csr),
      .res     (core_res)
   );

   cdt_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_item (core_res),
      .space     (out_space),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  (rsp_item)
   );

   // Spread the response beat onto the channel.
   assign rsp_chan.minutes_left  = rsp_item.minutes_left;
   assign rsp_chan.seconds_left  = rsp_item.seconds_left;
   assign rsp_chan.tenths_left   = rsp_item.tenths_left;
   assign rsp_chan.shown_state   = rsp_item.shown_state;
   assign rsp_chan.led_lit       = rsp_item.led_lit;
   assign rsp_chan.report_pulse  = rsp_item.report_pulse;
   assign rsp_chan.expired       = rsp_item.expired;
   assign rsp_chan.load_rejected = rsp_item.load_rejected;

endmodule

/* tb/tb.sv */
// Testbench of the countdown timer: directed and random events checked against a predictor.
module tb;
   import cdt_pkg::*;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int MAX_WAIT      = 17;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_MAX    = 10;
   localparam int PHASES        = 6;
   localparam int PHASE_EVENTS  = 320;

   // Event codes that the block must ignore.
   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   // Predicted state of the timer.
   typedef struct {
      logic [5:0] mins;
      logic [5:0] secs;
      logic [3:0] tenths;
      logic       armed;
      logic       running;
      show_type   shown;
      logic       led;
      logic [7:0] blink_cnt;
      logic [7:0] report_cnt;
      logic [3:0] loaded;
   } timer_state_type;

   logic clock;
   logic reset;

   cdt_req_if req_chan();
   cdt_rsp_if rsp_chan();
   cdt_csr_if csr_chan();

   countdown_timer_min_sec_tenths dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   timer_state_type timer_now;
   logic [7:0]      blink_limit;
   logic [7:0]      report_limit;
   rsp_beat_type    pending_results[$];

   int  mismatches;
   int  beats_checked;
   int  events_sent;
   int  expiries;
   int  pulses;
   int  rejects;
   int  cycle_count;
   bit  no_idle;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Run limit: a hang in either channel ends here.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: run timed out after %0d cycles", cycle_count);
      $display("tb: FAIL");
      $finish;
   end

   // Wait drawn for each beat; a stretch flag turns idling off for a while.
   function automatic int draw_wait();
      if (no_idle || $urandom_range(0, 2) == 0)
         return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic string beat_text(rsp_beat_type b);
      return $sformatf("%0d:%0d.%0d state %0d led %b pulse %b expired %b rejected %b",
                       b.minutes_left, b.seconds_left, b.tenths_left, b.shown_state,
                       b.led_lit, b.report_pulse, b.expired, b.load_rejected);
   endfunction

   // Applies one event to the predicted state and returns the beat it should produce.
   function automatic rsp_beat_type advance_timer(req_beat_type ev);
      rsp_beat_type res;
      logic [8:0]   blink_next;
      logic [8:0]   report_next;
      bit           at_zero;
      res = '0;
      at_zero = 1'b0;
      case (ev.mode)
         MODE_TICK: begin
            if (timer_now.running) begin
               // Count down with borrow; a tick at zero time expires instead.
               if (timer_now.tenths != 0) begin
                  timer_now.tenths = timer_now.tenths - 4'd1;
               end else if (timer_now.secs != 0) begin
                  timer_now.secs   = timer_now.secs - 6'd1;
                  timer_now.tenths = TENTHS_TOP;
               end else if (timer_now.mins != 0) begin
                  timer_now.mins   = timer_now.mins - 6'd1;
                  timer_now.secs   = SECONDS_TOP;
                  timer_now.tenths = TENTHS_TOP;
               end else begin
                  at_zero = 1'b1;
               end
               // Blink and report counters wrap once they reach their limits.
               blink_next = {1'b0, timer_now.blink_cnt} + 9'd1;
               if (blink_next >= {1'b0, blink_limit}) begin
                  blink_next    = '0;
                  timer_now.led = ~timer_now.led;
               end
               timer_now.blink_cnt = blink_next[7:0];
               report_next = {1'b0, timer_now.report_cnt} + 9'd1;
               if (report_next >= {1'b0, report_limit}) begin
                  report_next = '0;
                  if (timer_now.tenths == timer_now.loaded)
                     res.report_pulse = 1'b1;
               end
               timer_now.report_cnt = report_next[7:0];
               if (at_zero) begin
                  res.expired       = 1'b1;
                  timer_now.running = 1'b0;
                  timer_now.armed   = 1'b0;
                  timer_now.shown   = SHOW_STOP;
                  timer_now.led     = 1'b1;
               end
            end
         end
         MODE_LOAD: begin
            if (!timer_now.armed) begin
               if (ev.load_minutes <= MINUTES_TOP && ev.load_seconds <= SECONDS_TOP &&
                   ev.load_tenths <= TENTHS_TOP) begin
                  timer_now.mins   = ev.load_minutes[5:0];
                  timer_now.secs   = ev.load_seconds[5:0];
                  timer_now.tenths = ev.load_tenths;
                  timer_now.loaded = ev.load_tenths;
                  timer_now.armed  = 1'b1;
                  timer_now.led    = 1'b0;
               end else begin
                  res.load_rejected = 1'b1;
               end
            end
         end
         MODE_START: begin
            if (timer_now.armed) begin
               timer_now.running = 1'b1;
               timer_now.shown   = SHOW_RUN;
            end
         end
         MODE_PAUSE: begin
            if (timer_now.armed) begin
               timer_now.running = 1'b0;
               timer_now.led     = 1'b1;
               timer_now.shown   = SHOW_PAUSE;
            end
         end
         MODE_STOP: begin
            if (timer_now.armed) begin
               timer_now.mins       = '0;
               timer_now.secs       = '0;
               timer_now.tenths     = '0;
               timer_now.report_cnt = '0;
               timer_now.running    = 1'b0;
               timer_now.armed      = 1'b0;
               timer_now.led        = 1'b0;
               timer_now.shown      = SHOW_STOP;
            end
         end
         default: ;
      endcase
      expiries += res.expired;
      pulses   += res.report_pulse;
      rejects  += res.load_rejected;
      res.minutes_left = timer_now.mins;
      res.seconds_left = timer_now.secs;
      res.tenths_left  = timer_now.tenths;
      res.shown_state  = timer_now.shown;
      res.led_lit      = timer_now.led;
      return res;
   endfunction

   // Sends one event beat and records the beat it should produce.
   task automatic send_event(input logic [2:0] mode, input logic [6:0] mins,
                             input logic [6:0] secs, input logic [3:0] tenths);
      req_beat_type ev;
      int           gap;
      ev.mode         = mode;
      ev.load_minutes = mins;
      ev.load_seconds = secs;
      ev.load_tenths  = tenths;
      gap = draw_wait();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.mode         <= ev.mode;
      req_chan.load_minutes <= ev.load_minutes;
      req_chan.load_seconds <= ev.load_seconds;
      req_chan.load_tenths  <= ev.load_tenths;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      pending_results.push_back(advance_timer(ev));
      events_sent++;
   endtask

   // Non-load events carry random load fields, which the block must not use.
   task automatic send_op(input logic [2:0] mode);
      send_event(mode, 7'($urandom), 7'($urandom), 4'($urandom));
   endtask

   task automatic send_load(input logic [6:0] mins, input logic [6:0] secs,
                            input logic [3:0] tenths);
      send_event(MODE_LOAD, mins, secs, tenths);
   endtask

   // Stops sending until every predicted beat has come back.
   task automatic wait_all_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Writes both limits back to back; called only while no event is in flight.
   task automatic set_timing(input logic [7:0] blink, input logic [7:0] report);
      csr_chan.valid <= 1'b1;
      csr_chan.addr  <= CSR_BLINK_TICKS;
      csr_chan.wdata <= blink;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      blink_limit = blink;
      csr_chan.addr  <= CSR_REPORT_TICKS;
      csr_chan.wdata <= report;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      report_limit = report;
      csr_chan.valid <= 1'b0;
   endtask

   // Result side: random stalls before each beat.
   initial begin : rsp_side
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
      end
   end

   // Compares each result beat with the oldest prediction.
   always @(posedge clock) begin : check_beat
      rsp_beat_type got;
      rsp_beat_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.minutes_left  = rsp_chan.minutes_left;
         got.seconds_left  = rsp_chan.seconds_left;
         got.tenths_left   = rsp_chan.tenths_left;
         got.shown_state   = show_type'(rsp_chan.shown_state);
         got.led_lit       = rsp_chan.led_lit;
         got.report_pulse  = rsp_chan.report_pulse;
         got.expired       = rsp_chan.expired;
         got.load_rejected = rsp_chan.load_rejected;
         beats_checked++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("tb: beat with nothing predicted at %0t: %s", $time, beat_text(got));
         end else begin
            want = pending_results.pop_front();
            if (got.minutes_left !== want.minutes_left ||
                got.seconds_left !== want.seconds_left ||
                got.tenths_left !== want.tenths_left ||
                got.shown_state !== want.shown_state ||
                got.led_lit !== want.led_lit ||
                got.report_pulse !== want.report_pulse ||
                got.expired !== want.expired ||
                got.load_rejected !== want.load_rejected) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("tb: mismatch at %0t: expected %s, got %s",
                           $time, beat_text(want), beat_text(got));
            end
         end
      end
   end

   // Events on an unarmed timer and the spare codes change nothing.
   task automatic test_idle_events();
      send_op(MODE_TICK);
      send_op(MODE_START);
      send_op(MODE_PAUSE);
      send_op(MODE_STOP);
      for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
         send_event(3'(m), 7'h7F, 7'h7F, 4'hF);
      wait_all_results();
   endtask

   // Range checks on loads, the largest legal time, and a load while armed.
   task automatic test_load_checks();
      send_load(7'd60, 7'd0, 4'd0);
      send_load(7'd0, 7'd60, 4'd0);
      send_load(7'd0, 7'd0, 4'd10);
      send_load(7'h7F, 7'h7F, 4'hF);
      send_load(MINUTES_TOP, SECONDS_TOP, TENTHS_TOP);
      send_load(7'd0, 7'd0, 4'd0);
      send_op(MODE_STOP);
      wait_all_results();
   endtask

   // Borrow across minutes, ticks while paused, and expiry at zero time.
   task automatic test_countdown_edges();
      send_load(7'd1, 7'd0, 4'd0);
      send_op(MODE_START);
      send_op(MODE_TICK);
      send_op(MODE_PAUSE);
      send_op(MODE_TICK);
      send_op(MODE_START);
      send_op(MODE_TICK);
      send_op(MODE_STOP);
      send_load(7'd0, 7'd0, 4'd1);
      send_op(MODE_START);
      send_op(MODE_TICK);
      send_op(MODE_TICK);
      send_op(MODE_TICK);
      wait_all_results();
   endtask

   // One load-start-tick session with random content, some noise and broken runs.
   task automatic run_session();
      int         pick;
      int         total;
      int         ticks;
      logic [6:0] mins;
      logic [6:0] secs;
      logic [3:0] tenths;
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 5))
            send_event(3'($urandom_range(0, 7)), 7'($urandom), 7'($urandom), 4'($urandom));
      end
      // Usually clear an armed timer first; otherwise the next load is ignored.
      if (timer_now.armed && $urandom_range(0, 3) != 0)
         send_op(MODE_STOP);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         mins = 7'd0;
         secs = 7'($urandom_range(0, 3));
      end else if (pick < 9) begin
         mins = 7'($urandom_range(0, 1));
         secs = 7'($urandom_range(0, 59));
      end else begin
         mins = 7'($urandom_range(0, 59));
         secs = 7'($urandom_range(0, 59));
      end
      tenths = 4'($urandom_range(0, 9));
      if ($urandom_range(0, 7) == 0)
         send_load(mins, secs, 4'($urandom_range(10, 15)));
      send_load(mins, secs, tenths);
      send_op(MODE_START);
      // Short times run out to expiry; long ones are cut off after a while.
      total = mins * 600 + secs * 10 + tenths;
      ticks = (total < 80) ? total + 1 + $urandom_range(0, 3) : $urandom_range(10, 80);
      repeat (ticks) begin
         if ($urandom_range(0, 24) == 0) begin
            send_op(MODE_PAUSE);
            repeat ($urandom_range(0, 3)) send_op(MODE_TICK);
            send_op(MODE_START);
         end
         send_op(MODE_TICK);
      end
      if ($urandom_range(0, 19) == 0)
         wait_all_results();
   endtask

   // Random sessions under a series of blink and report limits, extremes included.
   task automatic test_timing_sweep();
      logic [7:0] blink_set [PHASES] = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd7, 8'd5};
      logic [7:0] report_set[PHASES] = '{8'd1, 8'd255, 8'd0, 8'd10, 8'd20, 8'd100};
      int         first;
      for (int p = 0; p < PHASES; p++) begin
         wait_all_results();
         if (p == 4)
            set_timing(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
         else
            set_timing(blink_set[p], report_set[p]);
         first = events_sent;
         while (events_sent - first < PHASE_EVENTS)
            run_session();
      end
      no_idle = 1'b0;
   endtask

   // Main sequence.
   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.mode         <= MODE_TICK;
      req_chan.load_minutes <= '0;
      req_chan.load_seconds <= '0;
      req_chan.load_tenths  <= '0;
      csr_chan.valid        <= 1'b0;
      csr_chan.addr         <= CSR_BLINK_TICKS;
      csr_chan.wdata        <= '0;
      no_idle       = 1'b0;
      mismatches    = 0;
      beats_checked = 0;
      events_sent   = 0;
      expiries      = 0;
      pulses        = 0;
      rejects       = 0;
      blink_limit   = BLINK_TICKS_RESET;
      report_limit  = REPORT_TICKS_RESET;
      timer_now.mins       = '0;
      timer_now.secs       = '0;
      timer_now.tenths     = '0;
      timer_now.armed      = 1'b0;
      timer_now.running    = 1'b0;
      timer_now.shown      = SHOW_INPUT;
      timer_now.led        = 1'b1;
      timer_now.blink_cnt  = '0;
      timer_now.report_cnt = '0;
      timer_now.loaded     = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_idle_events();
      test_load_checks();
      test_countdown_edges();
      test_timing_sweep();

      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      mismatches += pending_results.size();

      $display("tb: %0d events sent, %0d beats checked over %0d limit settings",
               events_sent, beats_checked, PHASES + 1);
      $display("tb: %0d expiries, %0d report pulses, %0d rejected loads, %0d mismatches",
               expiries, pulses, rejects, mismatches);
      if (mismatches == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
